### src/ssfd_pkg.sv
// ----------------------------------------------------------------------------
// ssfd_pkg: shared types and constants of the supersample filter/downsample
// Pixel and tap types, item control fields, column and row phase codes, and
// the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package ssfd_pkg;

  // Pixel format: three unsigned Q4.12 channels
  localparam int CHAN_W = 16;
  localparam int N_CH   = 3;
  localparam int N_TAPS = 5;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [N_CH-1:0]  pixel_t;
  // Tap 0 is the newest pixel, tap 4 the oldest
  typedef pixel_t [N_TAPS-1:0] taps_t;

  // Sum of up to three filtered values, and of a cell line entry
  localparam int SUM_W  = 18;
  localparam int LINE_W = 20;

  localparam int OUT_COL_W   = 9;
  localparam int WIDTH_REG_W = 10;
  localparam int CFG_IDX_W   = 2;

  localparam int SSFD_MAX_CELLS   = 512;
  localparam int SSFD_QUEUE_DEPTH = 4;

  // Position of a filtered column within its cell
  localparam logic [1:0] SUB_FIRST = 2'd0;
  localparam logic [1:0] SUB_MID   = 2'd1;
  localparam logic [1:0] SUB_LAST  = 2'd2;

  // Row within the current cell row
  localparam logic [1:0] PHASE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_MID   = 2'd1;
  localparam logic [1:0] PHASE_LAST  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd3;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RST  = 10'd512;
  localparam logic [CHAN_W-1:0]      OUTER_RST  = 16'd7871;
  localparam logic [CHAN_W-1:0]      NEAR_RST   = 16'd15329;
  localparam logic [CHAN_W-1:0]      CENTER_RST = 16'd19209;

  typedef struct packed {
    logic [CHAN_W-1:0] outer;
    logic [CHAN_W-1:0] near;
    logic [CHAN_W-1:0] center;
  } coef_t;

  // Control fields of one queued beat
  typedef struct packed {
    logic       last;     // last input column: two extra clamped columns
    logic [1:0] sub;      // position of the main filtered column in its cell
    logic [1:0] phase;    // row phase of the cell row
    logic       row_end;  // completing cell is the last of the row
  } item_ctl_t;

endpackage

### src/ssfd_ram.sv
// ----------------------------------------------------------------------------
// ssfd_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssfd_ram #(
  parameter int DATA_W = 60,
  parameter int DEPTH  = 512,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/ssfd_front.sv
// ----------------------------------------------------------------------------
// ssfd_front: pixel intake and column classification
// Tracks column and row phase, keeps the four-pixel tap window with edge
// clamping, and emits one queue beat per input column that makes a filtered column due.
// ----------------------------------------------------------------------------
module ssfd_front import ssfd_pkg::*; #(
  parameter int MAX_CELLS = SSFD_MAX_CELLS,
  localparam int CW       = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  pixel_t                 cur_pix,
  input  logic                   frame_start,
  input  logic [WIDTH_REG_W-1:0] width_cells,
  output logic                   push,
  output taps_t                  taps,
  output item_ctl_t              ctl,
  output logic [CW-1:0]          cell_idx
);

  logic [CW-1:0] cell_idx_r, cell_idx_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic [1:0]    phase_r, phase_nxt;
  pixel_t [3:0]  win_r, win_nxt;

  logic [CW-1:0] cells_m1;
  logic [CW-1:0] eff_cell, col_cell, main_cell;
  logic [1:0]    eff_sub, eff_phase, col_sub, main_sub;
  logic          over, is_last, col_zero, main_valid;
  pixel_t [3:0]  eff_win;

  // Clamp the configured width to 1..MAX_CELLS
  always_comb begin
    if (32'(width_cells) > 32'(MAX_CELLS)) begin
      cells_m1 = CW'(MAX_CELLS - 1);
    end else if (width_cells == '0) begin
      cells_m1 = '0;
    end else begin
      cells_m1 = CW'(width_cells - WIDTH_REG_W'(1));
    end
  end

  // Classify the incoming column
  always_comb begin
    eff_cell  = frame_start ? '0 : cell_idx_r;
    eff_sub   = frame_start ? SUB_FIRST : sub_r;
    eff_phase = frame_start ? PHASE_FIRST : phase_r;

    over     = eff_cell > cells_m1;
    col_cell = over ? cells_m1 : eff_cell;
    col_sub  = over ? SUB_LAST : eff_sub;

    is_last    = (col_cell == cells_m1) && (col_sub == SUB_LAST);
    col_zero   = (col_cell == '0) && (col_sub == SUB_FIRST);
    main_valid = !((col_cell == '0) && (col_sub != SUB_LAST));

    // Main filtered column sits two input columns back
    case (col_sub)
      SUB_LAST: begin
        main_cell = col_cell;
        main_sub  = SUB_FIRST;
      end
      SUB_MID: begin
        main_cell = col_cell - CW'(1);
        main_sub  = SUB_LAST;
      end
      default: begin
        main_cell = col_cell - CW'(1);
        main_sub  = SUB_MID;
      end
    endcase

    // Fill the window with the edge pixel at row start
    for (int i = 0; i < 4; i++) begin
      eff_win[i] = col_zero ? cur_pix : win_r[i];
    end
  end

  // Beat toward the back end
  always_comb begin
    push        = accept && main_valid;
    taps[0]     = cur_pix;
    for (int i = 0; i < 4; i++) begin
      taps[i+1] = eff_win[i];
    end
    ctl.last    = is_last;
    ctl.sub     = main_sub;
    ctl.phase   = eff_phase;
    ctl.row_end = (main_cell == cells_m1);
    cell_idx    = main_cell;
  end

  // Advance counters and shift the window
  always_comb begin
    win_nxt[0] = cur_pix;
    for (int i = 1; i < 4; i++) begin
      win_nxt[i] = eff_win[i-1];
    end
    if (is_last) begin
      cell_idx_nxt = '0;
      sub_nxt      = SUB_FIRST;
      phase_nxt    = (eff_phase == PHASE_LAST) ? PHASE_FIRST : eff_phase + 2'd1;
    end else if (col_sub == SUB_LAST) begin
      cell_idx_nxt = col_cell + CW'(1);
      sub_nxt      = SUB_FIRST;
      phase_nxt    = eff_phase;
    end else begin
      cell_idx_nxt = col_cell;
      sub_nxt      = col_sub + 2'd1;
      phase_nxt    = eff_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_idx_r <= '0;
      sub_r      <= SUB_FIRST;
      phase_r    <= PHASE_FIRST;
      win_r      <= '0;
    end else if (accept) begin
      cell_idx_r <= cell_idx_nxt;
      sub_r      <= sub_nxt;
      phase_r    <= phase_nxt;
      win_r      <= win_nxt;
    end
  end

  a_codes_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_r <= SUB_LAST) && (phase_r <= PHASE_LAST))
    else $error("front column or phase counter out of range");

  a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (push && ctl.last) |-> (ctl.row_end && ctl.sub == SUB_FIRST))
    else $error("last column beat does not close the row");

endmodule

### src/ssfd_queue.sv
// ----------------------------------------------------------------------------
// ssfd_queue: small FIFO between front and back
// Register-based queue that lets intake and processing stall independently.
// ----------------------------------------------------------------------------
module ssfd_queue #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 4,
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push_ok, pop_ok;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign push_ok    = push && !full;
  assign pop_ok     = pop && head_valid;

  // Track occupancy
  always_comb begin
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

endmodule

### src/ssfd_back.sv
// ----------------------------------------------------------------------------
// ssfd_back: filter, cell accumulation and divide-by-nine
// Pipeline: multiply, round/saturate, row partial sum, cell line update,
// reciprocal multiply, output register. The whole pipe holds while a
// result waits at the output.
// ----------------------------------------------------------------------------
module ssfd_back import ssfd_pkg::*; #(
  parameter int MAX_CELLS = SSFD_MAX_CELLS,
  localparam int CW       = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  coef_t                coefs,
  input  logic                 q_valid,
  input  taps_t                q_taps,
  input  item_ctl_t            q_ctl,
  input  logic [CW-1:0]        q_cell,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pixel_t               out_pix,
  output logic [OUT_COL_W-1:0] out_column,
  output logic                 out_row_end
);

  localparam int PRE_W      = CHAN_W + 1;
  localparam int PROD_W     = CHAN_W + PRE_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FILT_SHIFT = 16;
  localparam int BIAS_W     = LINE_W + 1;
  localparam int DIV_SHIFT  = 23;
  localparam int RECIP_W    = 20;
  localparam int DPROD_W    = BIAS_W + RECIP_W;
  localparam int AVG_W      = DPROD_W - DIV_SHIFT;
  localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(32768);
  localparam logic [RECIP_W-1:0] RECIP9     = 20'd932068;   // ceil(2^23 / 9)
  localparam logic [BIAS_W-1:0]  DIV_ROUND  = BIAS_W'(4);
  localparam logic [CHAN_W-1:0]  CHAN_MAX   = '1;

  logic advance;

  // Stage 1: products of the three kernels
  logic [PROD_W-1:0] prod_nxt [3][N_CH][3];
  logic [PROD_W-1:0] prod_r   [3][N_CH][3];
  logic              s1_valid_r;
  item_ctl_t         s1_ctl_r;
  logic [CW-1:0]     s1_cell_r;

  // Stage 2: filtered values
  chan_t         filt_nxt [3][N_CH];
  chan_t         filt_r   [3][N_CH];
  logic          s2_valid_r;
  item_ctl_t     s2_ctl_r;
  logic [CW-1:0] s2_cell_r;

  // Stage 3: cell row sums, line memory data arrives
  logic [SUM_W-1:0] cell_sum_nxt [N_CH];
  logic [SUM_W-1:0] cell_sum_r   [N_CH];
  logic [SUM_W-1:0] partial_r    [N_CH];
  logic             s3_valid_r;
  item_ctl_t        s3_ctl_r;
  logic [CW-1:0]    s3_cell_r;

  // Stage 4: nine-sample totals with rounding bias
  logic [BIAS_W-1:0] biased_nxt [N_CH];
  logic [BIAS_W-1:0] biased_r   [N_CH];
  logic              s4_valid_r;
  logic              s4_row_end_r;
  logic [CW-1:0]     s4_cell_r;

  // Stage 5: reciprocal products
  logic [DPROD_W-1:0] dprod_r [N_CH];
  logic               s5_valid_r;
  logic               s5_row_end_r;
  logic [CW-1:0]      s5_cell_r;

  // Output register
  logic                 out_valid_r;
  pixel_t               out_pix_r, out_pix_nxt;
  logic [OUT_COL_W-1:0] out_column_r;
  logic                 out_row_end_r;

  // Line memory
  logic [N_CH*LINE_W-1:0] line_rdata, line_wdata;
  logic [LINE_W-1:0]      line_sum [N_CH];
  logic [LINE_W-1:0]      line_prev [N_CH];
  logic                   line_we, s3_complete;
  logic                   line_fwd_hit_r;
  logic [N_CH*LINE_W-1:0] line_fwd_r;

  // Hold the whole pipe while a result waits
  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && q_valid;

  // Pre-add symmetric taps and multiply
  always_comb begin
    logic [PRE_W-1:0] pre_o, pre_n, pre_c;
    for (int k = 0; k < 3; k++) begin
      for (int ch = 0; ch < N_CH; ch++) begin
        pre_o = PRE_W'(q_taps[4-k][ch]) + PRE_W'(q_taps[0][ch]);
        if (k == 0) begin
          pre_n = PRE_W'(q_taps[3][ch]) + PRE_W'(q_taps[1][ch]);
        end else begin
          pre_n = PRE_W'(q_taps[3-k][ch]) + PRE_W'(q_taps[0][ch]);
        end
        pre_c = PRE_W'(q_taps[2-k][ch]);
        prod_nxt[k][ch][0] = PROD_W'(coefs.outer)  * PROD_W'(pre_o);
        prod_nxt[k][ch][1] = PROD_W'(coefs.near)   * PROD_W'(pre_n);
        prod_nxt[k][ch][2] = PROD_W'(coefs.center) * PROD_W'(pre_c);
      end
    end
  end

  // Sum products, round to Q4.12 and saturate
  always_comb begin
    logic [ACC_W-1:0] acc;
    for (int k = 0; k < 3; k++) begin
      for (int ch = 0; ch < N_CH; ch++) begin
        acc = ACC_W'(prod_r[k][ch][0]) + ACC_W'(prod_r[k][ch][1])
            + ACC_W'(prod_r[k][ch][2]) + ROUND_HALF;
        if (|acc[ACC_W-1:CHAN_W+FILT_SHIFT]) begin
          filt_nxt[k][ch] = CHAN_MAX;
        end else begin
          filt_nxt[k][ch] = acc[CHAN_W+FILT_SHIFT-1:FILT_SHIFT];
        end
      end
    end
  end

  // Accumulate filtered columns of the current cell
  always_comb begin
    logic [SUM_W-1:0] base, extra;
    for (int ch = 0; ch < N_CH; ch++) begin
      base  = (s2_ctl_r.sub == SUB_FIRST) ? '0 : partial_r[ch];
      extra = s2_ctl_r.last ? SUM_W'(filt_r[1][ch]) + SUM_W'(filt_r[2][ch]) : '0;
      cell_sum_nxt[ch] = base + SUM_W'(filt_r[0][ch]) + extra;
    end
  end

  // Combine with the line entry of earlier rows
  always_comb begin
    s3_complete = s3_ctl_r.last || (s3_ctl_r.sub == SUB_LAST);
    line_we     = advance && s3_valid_r && s3_complete && (s3_ctl_r.phase != PHASE_LAST);
    for (int ch = 0; ch < N_CH; ch++) begin
      line_prev[ch]  = line_fwd_hit_r ? line_fwd_r[ch*LINE_W +: LINE_W]
                                      : line_rdata[ch*LINE_W +: LINE_W];
      line_sum[ch]   = line_prev[ch] + LINE_W'(cell_sum_r[ch]);
      biased_nxt[ch] = BIAS_W'(line_sum[ch]) + DIV_ROUND;
      line_wdata[ch*LINE_W +: LINE_W] =
        (s3_ctl_r.phase == PHASE_FIRST) ? LINE_W'(cell_sum_r[ch]) : line_sum[ch];
    end
  end

  // Scale the reciprocal product down and saturate
  always_comb begin
    logic [AVG_W-1:0] avg;
    for (int ch = 0; ch < N_CH; ch++) begin
      avg = dprod_r[ch][DPROD_W-1:DIV_SHIFT];
      out_pix_nxt[ch] = (|avg[AVG_W-1:CHAN_W]) ? CHAN_MAX : avg[CHAN_W-1:0];
    end
  end

  ssfd_ram #(
    .DATA_W (N_CH * LINE_W),
    .DEPTH  (MAX_CELLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (s3_cell_r),
    .wdata (line_wdata),
    .re    (advance),
    .raddr (s2_cell_r),
    .rdata (line_rdata)
  );

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      s3_valid_r     <= 1'b0;
      s4_valid_r     <= 1'b0;
      s5_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      line_fwd_hit_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r     <= q_valid;
      s2_valid_r     <= s1_valid_r;
      s3_valid_r     <= s2_valid_r;
      s4_valid_r     <= s3_valid_r && s3_complete && (s3_ctl_r.phase == PHASE_LAST);
      s5_valid_r     <= s4_valid_r;
      out_valid_r    <= s5_valid_r;
      // Forward a line entry written in the same cycle it is read
      line_fwd_hit_r <= line_we && (s3_cell_r == s2_cell_r);
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r        <= prod_nxt;
      s1_ctl_r      <= q_ctl;
      s1_cell_r     <= q_cell;
      filt_r        <= filt_nxt;
      s2_ctl_r      <= s1_ctl_r;
      s2_cell_r     <= s1_cell_r;
      cell_sum_r    <= cell_sum_nxt;
      s3_ctl_r      <= s2_ctl_r;
      s3_cell_r     <= s2_cell_r;
      line_fwd_r    <= line_wdata;
      biased_r      <= biased_nxt;
      s4_row_end_r  <= s3_ctl_r.row_end;
      s4_cell_r     <= s3_cell_r;
      for (int ch = 0; ch < N_CH; ch++) begin
        dprod_r[ch] <= DPROD_W'(biased_r[ch]) * DPROD_W'(RECIP9);
      end
      s5_row_end_r  <= s4_row_end_r;
      s5_cell_r     <= s4_cell_r;
      out_pix_r     <= out_pix_nxt;
      out_column_r  <= OUT_COL_W'(s5_cell_r);
      out_row_end_r <= s5_row_end_r;
    end
  end

  // Keep the running sum of the cell in this row
  always_ff @(posedge clk) begin
    if (advance && s2_valid_r) begin
      partial_r <= cell_sum_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pix     = out_pix_r;
  assign out_column  = out_column_r;
  assign out_row_end = out_row_end_r;

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s5_valid_r))
    else $error("result appeared without a beat in the last stage");

endmodule

### src/supersample_filter_downsample_unit.sv
// ----------------------------------------------------------------------------
// supersample_filter_downsample_unit: 5-tap filter and 3x3 box downsample
// Top level: configuration registers, intake front, beat queue, back end.
// ----------------------------------------------------------------------------
// Takes one supersampled RGB pixel per clock in raster order and, while the
// output does not stall, sustains that rate indefinitely, including at row
// ends, where the two clamped edge columns are filtered by parallel kernel
// units. After the pixel that completes a cell is taken, its result passes
// the six-stage back-end pipeline (multiply, round, row sum, cell line
// update, reciprocal multiply, output). A four-beat queue between intake
// and back end keeps the input flowing while the output stalls, until it
// fills. The cell line memory needs no clearing after reset: the first row
// of every cell row writes each entry before it is used. Change configuration
// only while the block is idle, and mark the first pixel of each frame.
// ----------------------------------------------------------------------------
module supersample_filter_downsample_unit import ssfd_pkg::*; #(
  parameter int MAX_CELLS = SSFD_MAX_CELLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input pixels
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAN_W-1:0]      in_red,
  input  logic [CHAN_W-1:0]      in_green,
  input  logic [CHAN_W-1:0]      in_blue,
  input  logic                   in_frame_start,
  // Output cells
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAN_W-1:0]      out_red,
  output logic [CHAN_W-1:0]      out_green,
  output logic [CHAN_W-1:0]      out_blue,
  output logic [OUT_COL_W-1:0]   out_column,
  output logic                   out_row_end,
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CHAN_W-1:0]      cfg_data
);

  localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int QW = $bits(taps_t) + $bits(item_ctl_t) + CW;

  logic [WIDTH_REG_W-1:0] width_r;
  coef_t                  coefs_r;

  pixel_t        in_pix, out_pix;
  logic          accept, push, q_full, q_valid, q_pop;
  taps_t         f_taps, q_taps;
  item_ctl_t     f_ctl, q_ctl;
  logic [CW-1:0] f_cell, q_cell;
  logic [QW-1:0] q_head;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r        <= WIDTH_RST;
      coefs_r.outer  <= OUTER_RST;
      coefs_r.near   <= NEAR_RST;
      coefs_r.center <= CENTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  width_r        <= cfg_data[WIDTH_REG_W-1:0];
        REG_OUTER:  coefs_r.outer  <= cfg_data;
        REG_NEAR:   coefs_r.near   <= cfg_data;
        REG_CENTER: coefs_r.center <= cfg_data;
        default: ;
      endcase
    end
  end

  // Intake
  assign in_pix[CH_RED]   = in_red;
  assign in_pix[CH_GREEN] = in_green;
  assign in_pix[CH_BLUE]  = in_blue;
  assign in_stall         = q_full;
  assign accept           = in_valid && !in_stall;

  ssfd_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cur_pix     (in_pix),
    .frame_start (in_frame_start),
    .width_cells (width_r),
    .push        (push),
    .taps        (f_taps),
    .ctl         (f_ctl),
    .cell_idx    (f_cell)
  );

  ssfd_queue #(
    .DATA_W (QW),
    .DEPTH  (SSFD_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({f_taps, f_ctl, f_cell}),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign {q_taps, q_ctl, q_cell} = q_head;

  ssfd_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .coefs       (coefs_r),
    .q_valid     (q_valid),
    .q_taps      (q_taps),
    .q_ctl       (q_ctl),
    .q_cell      (q_cell),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pix     (out_pix),
    .out_column  (out_column),
    .out_row_end (out_row_end)
  );

  assign out_red   = out_pix[CH_RED];
  assign out_green = out_pix[CH_GREEN];
  assign out_blue  = out_pix[CH_BLUE];

endmodule
